@@ design/quad_morphing_phase_oscillator_unit_macros.svh @@
// assertion helpers shared by the checker
`ifndef QUAD_MORPHING_PHASE_OSCILLATOR_UNIT_MACROS_SVH
`define QUAD_MORPHING_PHASE_OSCILLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define QMPO_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QMPO_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/qmpo_pkg.sv @@
package qmpo_pkg;

  localparam int LANES            = 4;
  localparam int LANE_W           = $clog2(LANES);
  localparam int CFG_IDX_W        = LANE_W + 1;
  localparam int RATIO_W          = 5;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SIN_IDX_W        = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SIN_POS_W        = 30 + SIN_IDX_W;
  localparam int SIN_VAL_W        = 15;
  localparam int VOLT5            = 20480;
  localparam int SHAPE_MAX        = 40960;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [2:0] {
    W_SIN,
    W_RSN,
    W_TRI,
    W_SAW,
    W_SQR
  } wave_t;

  typedef logic [RATIO_W-1:0] ratio_t;
  typedef logic [SIN_VAL_W-1:0] quarter_t [0:SINE_TABLE_DEPTH];

  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] shift;
    logic [15:0] shape;
  } lane_in_t;

  // quarter-wave sine, Q30 taylor series scaled to 5 V
  function automatic quarter_t build_quarter();
    quarter_t tbl;
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint e;
    int k;
    int n;
    for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TAYLOR_DIV[n];
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      e = (sum * 20480 + (64'sd1 <<< 29)) >>> 30;
      if (e > VOLT5) begin
        e = VOLT5;
      end
      tbl[k] = SIN_VAL_W'(e);
    end
    return tbl;
  endfunction

  localparam quarter_t QUARTER = build_quarter();

  function automatic wave_t pair_first(input logic [3:0] sec);
    wave_t w;
    unique case (sec)
      4'd0:    w = W_SIN;
      4'd1:    w = W_SAW;
      4'd2:    w = W_RSN;
      4'd3:    w = W_TRI;
      4'd4:    w = W_SQR;
      4'd5:    w = W_SIN;
      4'd6:    w = W_TRI;
      4'd7:    w = W_SAW;
      4'd8:    w = W_SQR;
      4'd9:    w = W_RSN;
      default: w = W_SIN;
    endcase
    return w;
  endfunction

  function automatic wave_t pair_second(input logic [3:0] sec);
    wave_t w;
    unique case (sec)
      4'd0:    w = W_SAW;
      4'd1:    w = W_RSN;
      4'd2:    w = W_TRI;
      4'd3:    w = W_SQR;
      4'd4:    w = W_SIN;
      4'd5:    w = W_TRI;
      4'd6:    w = W_SAW;
      4'd7:    w = W_SQR;
      4'd8:    w = W_RSN;
      4'd9:    w = W_SIN;
      default: w = W_SIN;
    endcase
    return w;
  endfunction

endpackage

@@ design/qmpo_lane.sv @@
module qmpo_lane (
  input  logic                     clk,
  input  logic                     en,
  input  qmpo_pkg::lane_in_t       lane_in,
  input  qmpo_pkg::ratio_t         ratio,
  output logic signed [15:0]       lane_out
);

  // stage a: lane phase and clamped morph position
  logic [31:0] p_r, p_nxt;
  logic [3:0]  sec_a_r;
  logic [11:0] frac_a_r;
  logic [31:0] phase_sum;
  logic [15:0] shape_c;

  always_comb begin
    phase_sum = lane_in.phase + lane_in.shift;
    p_nxt = 32'(phase_sum * 32'(ratio));
    shape_c = (lane_in.shape > 16'(qmpo_pkg::SHAPE_MAX)) ?
              16'(qmpo_pkg::SHAPE_MAX) : lane_in.shape;
  end

  // stage b: table lookup and interpolation product, plain shapes
  logic [30:0]                        rq;
  logic [qmpo_pkg::SIN_POS_W-1:0]     pos;
  logic [qmpo_pkg::SIN_IDX_W-1:0]     idx, ia, ib;
  logic [29:0]                        fr;
  logic [qmpo_pkg::SIN_VAL_W-1:0]     qa, qb, dd;
  logic [44:0]                        prod;
  logic signed [35:0]                 saw_x, saw_m;
  logic signed [33:0]                 tri_x, tri_m;
  logic signed [31:0]                 tri_d;

  logic [qmpo_pkg::SIN_VAL_W-1:0]     a_r, interp_r;
  logic                               neg_r, sqr_neg_r;
  logic signed [15:0]                 saw_r, tri_r;
  logic [3:0]                         sec_b_r;
  logic [11:0]                        frac_b_r;

  always_comb begin
    rq = p_r[30] ? (31'h4000_0000 - {1'b0, p_r[29:0]}) : {1'b0, p_r[29:0]};
    pos = qmpo_pkg::SIN_POS_W'(rq) *
          qmpo_pkg::SIN_POS_W'(qmpo_pkg::SINE_TABLE_DEPTH);
    idx = pos[qmpo_pkg::SIN_POS_W-1:30];
    fr  = pos[29:0];
    if (idx >= qmpo_pkg::SIN_IDX_W'(qmpo_pkg::SINE_TABLE_DEPTH)) begin
      ia = qmpo_pkg::SIN_IDX_W'(qmpo_pkg::SINE_TABLE_DEPTH);
      ib = ia;
    end else begin
      ia = idx;
      ib = idx + 1'b1;
    end
    qa = qmpo_pkg::QUARTER[ia];
    qb = qmpo_pkg::QUARTER[ib];
    dd = (qb >= qa) ? (qb - qa) : '0;
    prod = 45'(dd) * 45'(fr);

    saw_x = 36'(signed'(p_r));
    saw_m = (saw_x <<< 3) + (saw_x <<< 1);

    if (p_r < 32'h4000_0000) begin
      tri_d = signed'(p_r);
    end else if (p_r < 32'hC000_0000) begin
      tri_d = signed'(32'h8000_0000 - p_r);
    end else begin
      tri_d = signed'(p_r);
    end
    tri_x = 34'(tri_d);
    tri_m = (tri_x <<< 2) + tri_x;
  end

  // stage c: sine assembly and shape selection
  logic [15:0]        sin_mag;
  logic signed [15:0] sin_v, rsn_v, sqr_v;
  logic signed [16:0] rsn_w;
  qmpo_pkg::wave_t    k1, k2;
  logic signed [15:0] w1_nxt, w2_nxt;
  logic signed [15:0] w1_r, w2_r;
  logic [11:0]        frac_c_r;

  function automatic logic signed [15:0] pick(
    input qmpo_pkg::wave_t    kind,
    input logic signed [15:0] s_sin,
    input logic signed [15:0] s_rsn,
    input logic signed [15:0] s_tri,
    input logic signed [15:0] s_saw,
    input logic signed [15:0] s_sqr
  );
    logic signed [15:0] v;
    unique case (kind)
      qmpo_pkg::W_RSN: v = s_rsn;
      qmpo_pkg::W_TRI: v = s_tri;
      qmpo_pkg::W_SAW: v = s_saw;
      qmpo_pkg::W_SQR: v = s_sqr;
      default:         v = s_sin;
    endcase
    return v;
  endfunction

  always_comb begin
    sin_mag = {1'b0, a_r} + {1'b0, interp_r};
    sin_v = neg_r ? -signed'(sin_mag) : signed'(sin_mag);
    rsn_w = signed'({sin_mag, 1'b0}) - 17'sd20480;
    rsn_v = rsn_w[15:0];
    sqr_v = sqr_neg_r ? -16'sd20480 : 16'sd20480;
    k1 = qmpo_pkg::pair_first(sec_b_r);
    k2 = qmpo_pkg::pair_second(sec_b_r);
    w1_nxt = pick(k1, sin_v, rsn_v, tri_r, saw_r, sqr_v);
    w2_nxt = pick(k2, sin_v, rsn_v, tri_r, saw_r, sqr_v);
  end

  // stage d: cross-fade
  logic [12:0]        wgt1;
  logic signed [29:0] m1, m2, mix;

  always_comb begin
    wgt1 = 13'd4096 - {1'b0, frac_c_r};
    m1 = 30'(w1_r) * 30'(signed'({1'b0, wgt1}));
    m2 = 30'(w2_r) * 30'(signed'({1'b0, frac_c_r}));
    mix = m1 + m2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r       <= p_nxt;
      sec_a_r   <= shape_c[15:12];
      frac_a_r  <= shape_c[11:0];

      a_r       <= qa;
      interp_r  <= prod[44:30];
      neg_r     <= p_r[31];
      sqr_neg_r <= p_r[31];
      saw_r     <= saw_m[35:20];
      tri_r     <= tri_m[33:18];
      sec_b_r   <= sec_a_r;
      frac_b_r  <= frac_a_r;

      w1_r      <= w1_nxt;
      w2_r      <= w2_nxt;
      frac_c_r  <= frac_b_r;

      lane_out  <= mix[27:12];
    end
  end

endmodule

@@ design/quad_morphing_phase_oscillator_unit.sv @@
// Four-lane morphing phase oscillator.
// Input channel (in_valid / in_stall): one word per audio sample carrying the
// phase step and, for each lane, a morph position and a phase offset.
// Output channel (out_valid / out_stall): one word per accepted input word with
// the four lane voltages, signed Q4.12.
// Configuration: cfg_we writes cfg_data into ratio register cfg_index; only
// write while no word is in flight. Indexes past the last lane are dropped.
// An accepted word passes in order through phase add, lane phase multiply,
// sine table read and interpolation product, shape select, cross-fade and
// output register.
// Throughput: one word per cycle while the output is not stalled; the four
// lanes run side by side in a six-register pipeline that moves as a whole.
// A stalled output word holds and freezes the pipeline; in_stall is high
// exactly while the output word waits on out_stall.
// Reset clears the phase accumulator, empties the pipeline and sets every
// ratio to one.
module quad_morphing_phase_oscillator_unit (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [30:0]                        in_phase_step,
  input  logic [15:0]                        in_shape_lane1,
  input  logic [15:0]                        in_shape_lane2,
  input  logic [15:0]                        in_shape_lane3,
  input  logic [15:0]                        in_shape_lane4,
  input  logic [31:0]                        in_shift_lane1,
  input  logic [31:0]                        in_shift_lane2,
  input  logic [31:0]                        in_shift_lane3,
  input  logic [31:0]                        in_shift_lane4,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 out_lane1,
  output logic signed [15:0]                 out_lane2,
  output logic signed [15:0]                 out_lane3,
  output logic signed [15:0]                 out_lane4,

  input  logic                               cfg_we,
  input  logic [qmpo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qmpo_pkg::RATIO_W-1:0]       cfg_data
);

  localparam int STAGES = 5;

  logic                     en, accept;
  logic [31:0]              acc_r, acc_nxt;
  logic [STAGES-1:0]        vld_r;
  logic                     out_valid_r;
  qmpo_pkg::ratio_t         ratio_r [qmpo_pkg::LANES];
  qmpo_pkg::lane_in_t       lane_in_nxt [qmpo_pkg::LANES];
  qmpo_pkg::lane_in_t       lane_in_r [qmpo_pkg::LANES];
  logic signed [15:0]       lane_res [qmpo_pkg::LANES];
  logic signed [15:0]       out_r [qmpo_pkg::LANES];
  logic [15:0]              shape_in [qmpo_pkg::LANES];
  logic [31:0]              shift_in [qmpo_pkg::LANES];

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;
  assign acc_nxt  = acc_r + {1'b0, in_phase_step};

  always_comb begin
    shape_in[0] = in_shape_lane1;
    shape_in[1] = in_shape_lane2;
    shape_in[2] = in_shape_lane3;
    shape_in[3] = in_shape_lane4;
    shift_in[0] = in_shift_lane1;
    shift_in[1] = in_shift_lane2;
    shift_in[2] = in_shift_lane3;
    shift_in[3] = in_shift_lane4;
    for (int i = 0; i < qmpo_pkg::LANES; i++) begin
      lane_in_nxt[i].phase = acc_nxt;
      lane_in_nxt[i].shift = shift_in[i];
      lane_in_nxt[i].shape = shape_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < qmpo_pkg::LANES; i++) begin
        ratio_r[i] <= qmpo_pkg::RATIO_W'(1);
      end
    end else begin
      if (cfg_we && (cfg_index < qmpo_pkg::CFG_IDX_W'(qmpo_pkg::LANES))) begin
        ratio_r[cfg_index[qmpo_pkg::LANE_W-1:0]] <= cfg_data;
      end
      if (accept) begin
        acc_r <= acc_nxt;
      end
      if (en) begin
        vld_r       <= {vld_r[STAGES-2:0], accept};
        out_valid_r <= vld_r[STAGES-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < qmpo_pkg::LANES; i++) begin
        lane_in_r[i] <= lane_in_nxt[i];
        out_r[i]     <= lane_res[i];
      end
    end
  end

  for (genvar g = 0; g < qmpo_pkg::LANES; g++) begin : g_lane
    qmpo_lane u_lane (
      .clk      (clk),
      .en       (en),
      .lane_in  (lane_in_r[g]),
      .ratio    (ratio_r[g]),
      .lane_out (lane_res[g])
    );
  end

  assign out_valid = out_valid_r;
  assign out_lane1 = out_r[0];
  assign out_lane2 = out_r[1];
  assign out_lane3 = out_r[2];
  assign out_lane4 = out_r[3];

endmodule

@@ design/qmpo_checker.sv @@
`include "quad_morphing_phase_oscillator_unit_macros.svh"

module qmpo_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_lane1,
  input logic signed [15:0] out_lane2,
  input logic signed [15:0] out_lane3,
  input logic signed [15:0] out_lane4
);

  `QMPO_ASSERT_NXT(a_out_hold, clk, !rst_n, out_valid && out_stall, out_valid && $stable(out_lane1) && $stable(out_lane2) && $stable(out_lane3) && $stable(out_lane4), "stalled output word changed")

  `QMPO_ASSERT_IMP(a_stall_link, clk, !rst_n, 1'b1, in_stall == (out_valid && out_stall), "input stall does not follow blocked output")

  `QMPO_ASSERT_NXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid && !in_stall, "pipeline not empty after reset")

  `QMPO_ASSERT_IMP(a_volt_range, clk, !rst_n, out_valid, out_lane1 >= -20480 && out_lane1 <= 20480 && out_lane2 >= -20480 && out_lane2 <= 20480 && out_lane3 >= -20480 && out_lane3 <= 20480 && out_lane4 >= -20480 && out_lane4 <= 20480, "lane voltage beyond 5 V")

endmodule

bind quad_morphing_phase_oscillator_unit qmpo_checker u_qmpo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_lane1 (out_lane1),
  .out_lane2 (out_lane2),
  .out_lane3 (out_lane3),
  .out_lane4 (out_lane4)
);

@@ verif/quad_morphing_phase_oscillator_unit_checker.sv @@
module quad_morphing_phase_oscillator_unit_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [30:0]                    in_phase_step,
  input  logic [15:0]                    in_shape_lane1,
  input  logic [15:0]                    in_shape_lane2,
  input  logic [15:0]                    in_shape_lane3,
  input  logic [15:0]                    in_shape_lane4,
  input  logic [31:0]                    in_shift_lane1,
  input  logic [31:0]                    in_shift_lane2,
  input  logic [31:0]                    in_shift_lane3,
  input  logic [31:0]                    in_shift_lane4,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [15:0]             out_lane1,
  input  logic signed [15:0]             out_lane2,
  input  logic signed [15:0]             out_lane3,
  input  logic signed [15:0]             out_lane4,
  input  logic                           cfg_we,
  input  logic [qmpo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qmpo_pkg::RATIO_W-1:0]   cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             words_checked
);

  typedef logic [3:0][15:0] lane_volts_t;

  localparam qmpo_pkg::wave_t FIRST_OF [10] = '{
    qmpo_pkg::W_SIN, qmpo_pkg::W_SAW, qmpo_pkg::W_RSN, qmpo_pkg::W_TRI, qmpo_pkg::W_SQR,
    qmpo_pkg::W_SIN, qmpo_pkg::W_TRI, qmpo_pkg::W_SAW, qmpo_pkg::W_SQR, qmpo_pkg::W_RSN};
  localparam qmpo_pkg::wave_t SECOND_OF [10] = '{
    qmpo_pkg::W_SAW, qmpo_pkg::W_RSN, qmpo_pkg::W_TRI, qmpo_pkg::W_SQR, qmpo_pkg::W_SIN,
    qmpo_pkg::W_TRI, qmpo_pkg::W_SAW, qmpo_pkg::W_SQR, qmpo_pkg::W_RSN, qmpo_pkg::W_SIN};

  int quarter_volts [0:qmpo_pkg::SINE_TABLE_DEPTH];
  logic [31:0] running_phase;
  logic [qmpo_pkg::RATIO_W-1:0] lane_ratio [qmpo_pkg::LANES];
  lane_volts_t expected_volts [$];

  logic [3:0][15:0] shapes_seen;
  logic [3:0][31:0] shifts_seen;
  lane_volts_t volts_seen;

  assign shapes_seen = {in_shape_lane4, in_shape_lane3, in_shape_lane2, in_shape_lane1};
  assign shifts_seen = {in_shift_lane4, in_shift_lane3, in_shift_lane2, in_shift_lane1};
  assign volts_seen  = {out_lane4, out_lane3, out_lane2, out_lane1};

  // quarter-wave sine in Q30, scaled to 5 V
  initial begin
    longint unsigned x;
    longint unsigned term;
    longint acc;
    longint e;
    for (int k = 0; k <= qmpo_pkg::SINE_TABLE_DEPTH; k++) begin
      x = (qmpo_pkg::HALF_PI_Q30 * longint'(k)) / qmpo_pkg::SINE_TABLE_DEPTH;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      e = (acc * qmpo_pkg::VOLT5 + (longint'(1) <<< 29)) >>> 30;
      if (e > qmpo_pkg::VOLT5) begin
        e = qmpo_pkg::VOLT5;
      end
      quarter_volts[k] = int'(e);
    end
  end

  function automatic int sine_volts(input logic [31:0] p);
    logic [1:0] quad;
    longint unsigned r;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned fr;
    longint unsigned a;
    longint unsigned b;
    longint unsigned d;
    int v;
    quad = p[31:30];
    r = 64'(p[29:0]);
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    pos = r * 64'(qmpo_pkg::SINE_TABLE_DEPTH);
    idx = pos >> 30;
    fr = pos & 64'h3FFF_FFFF;
    if (idx >= 64'(qmpo_pkg::SINE_TABLE_DEPTH)) begin
      v = quarter_volts[qmpo_pkg::SINE_TABLE_DEPTH];
    end else begin
      a = 64'(quarter_volts[idx]);
      b = 64'(quarter_volts[idx + 1]);
      d = (b >= a) ? b - a : 64'd0;
      v = int'(a + ((d * fr) >> 30));
    end
    return quad[1] ? -v : v;
  endfunction

  function automatic int shape_volts(input qmpo_pkg::wave_t kind, input logic [31:0] p);
    longint s;
    longint d;
    longint pu;
    int v;
    pu = longint'(p);
    case (kind)
      qmpo_pkg::W_SAW: begin
        s = longint'(signed'(p));
        v = int'((10 * s) >>> 20);
      end
      qmpo_pkg::W_TRI: begin
        if (p < 32'h4000_0000) begin
          d = pu;
        end else if (p < 32'hC000_0000) begin
          d = 64'sd2147483648 - pu;
        end else begin
          d = pu - 64'sd4294967296;
        end
        v = int'((5 * d) >>> 18);
      end
      qmpo_pkg::W_SQR: v = p[31] ? -qmpo_pkg::VOLT5 : qmpo_pkg::VOLT5;
      qmpo_pkg::W_RSN: begin
        v = sine_volts(p);
        if (v < 0) begin
          v = -v;
        end
        v = 2 * v - qmpo_pkg::VOLT5;
      end
      default: v = sine_volts(p);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] lane_volts(input logic [15:0] shape, input logic [31:0] shift,
                                             input logic [qmpo_pkg::RATIO_W-1:0] ratio);
    logic [31:0] base;
    logic [63:0] prod;
    logic [15:0] pos;
    int sec;
    int fr;
    int w1;
    int w2;
    longint mix;
    base = running_phase + shift;
    prod = 64'(base) * 64'(ratio);
    pos = (shape > qmpo_pkg::SHAPE_MAX) ? 16'(qmpo_pkg::SHAPE_MAX) : shape;
    sec = int'(pos[15:12]);
    fr = int'(pos[11:0]);
    if (sec >= 10) begin
      w1 = shape_volts(qmpo_pkg::W_SIN, prod[31:0]);
      w2 = w1;
    end else begin
      w1 = shape_volts(FIRST_OF[sec], prod[31:0]);
      w2 = shape_volts(SECOND_OF[sec], prod[31:0]);
    end
    mix = longint'(w1) * longint'(4096 - fr) + longint'(w2) * longint'(fr);
    return 16'(mix >>> 12);
  endfunction

  always @(posedge clk) begin
    lane_volts_t want;
    if (!rst_n) begin
      running_phase = '0;
      for (int i = 0; i < qmpo_pkg::LANES; i++) begin
        lane_ratio[i] = qmpo_pkg::RATIO_W'(1);
      end
      expected_volts.delete();
      fail_count = 0;
      words_checked = 0;
    end else begin
      if (cfg_we && cfg_index < qmpo_pkg::LANES) begin
        lane_ratio[cfg_index] = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_volts.size() == 0) begin
          fail_count++;
          $display("%0t: output word with none expected, lane1 %0d", $time, out_lane1);
        end else begin
          want = expected_volts.pop_front();
          for (int i = 0; i < qmpo_pkg::LANES; i++) begin
            if (volts_seen[i] !== want[i]) begin
              fail_count++;
              $display("%0t: lane%0d expected %0d actual %0d", $time, i + 1,
                       $signed(want[i]), $signed(volts_seen[i]));
            end
          end
          words_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        running_phase = running_phase + 32'(in_phase_step);
        for (int i = 0; i < qmpo_pkg::LANES; i++) begin
          want[i] = lane_volts(shapes_seen[i], shifts_seen[i], lane_ratio[i]);
        end
        expected_volts.push_back(want);
      end
    end
    pending = expected_volts.size();
  end

endmodule

@@ verif/quad_morphing_phase_oscillator_unit_tb.sv @@
module quad_morphing_phase_oscillator_unit_tb;

  localparam int RANDOM_WORDS = 1700;
  localparam int PHASES       = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 240;
  localparam int SETTLE       = 12;

  localparam int FIRST_RATIOS [4] = '{0, 31, 16, 17};

  localparam logic [31:0] PHASE_EDGES [8] = '{32'h0000_0000, 32'h3FFF_FFFF, 32'h4000_0000,
                                              32'h7FFF_FFFF, 32'h8000_0000, 32'hBFFF_FFFF,
                                              32'hC000_0000, 32'hFFFF_FFFF};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [30:0] step_drv = '0;
  logic [3:0][15:0] shape_drv = '0;
  logic [3:0][31:0] shift_drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] lane1_v;
  logic signed [15:0] lane2_v;
  logic signed [15:0] lane3_v;
  logic signed [15:0] lane4_v;
  logic cfg_we = 1'b0;
  logic [qmpo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qmpo_pkg::RATIO_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int words_checked;
  int gap_max = 0;
  bit long_hold_req = 1'b0;
  int cycles = 0;
  int settings_used = 1;

  quad_morphing_phase_oscillator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_phase_step(step_drv),
    .in_shape_lane1(shape_drv[0]), .in_shape_lane2(shape_drv[1]),
    .in_shape_lane3(shape_drv[2]), .in_shape_lane4(shape_drv[3]),
    .in_shift_lane1(shift_drv[0]), .in_shift_lane2(shift_drv[1]),
    .in_shift_lane3(shift_drv[2]), .in_shift_lane4(shift_drv[3]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_lane1(lane1_v), .out_lane2(lane2_v), .out_lane3(lane3_v), .out_lane4(lane4_v),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  quad_morphing_phase_oscillator_unit_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_phase_step(step_drv),
    .in_shape_lane1(shape_drv[0]), .in_shape_lane2(shape_drv[1]),
    .in_shape_lane3(shape_drv[2]), .in_shape_lane4(shape_drv[3]),
    .in_shift_lane1(shift_drv[0]), .in_shift_lane2(shift_drv[1]),
    .in_shift_lane3(shift_drv[2]), .in_shift_lane4(shift_drv[3]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_lane1(lane1_v), .out_lane2(lane2_v), .out_lane3(lane3_v), .out_lane4(lane4_v),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // output side: random hold per word, one long hold on request
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_word(input logic [30:0] step, input logic [3:0][15:0] shapes,
                           input logic [3:0][31:0] shifts);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    step_drv <= step;
    shape_drv <= shapes;
    shift_drv <= shifts;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input int idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= qmpo_pkg::CFG_IDX_W'(idx);
    cfg_data <= qmpo_pkg::RATIO_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_shape();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 16'($urandom_range(0, qmpo_pkg::SHAPE_MAX));
    end else if (r < 85) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(0, 10) * 4096 + ($urandom_range(0, 1) ? 0 : 4095));
  endfunction

  function automatic logic [31:0] pick_shift();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom;
    end
    return {2'($urandom_range(0, 3)), 30'd0} + 32'($urandom_range(0, 2)) - 32'd1;
  endfunction

  function automatic logic [30:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 31'($urandom);
    end else if (r < 80) begin
      return 31'($urandom_range(0, 1 << 20));
    end else if (r < 90) begin
      return '0;
    end
    return 31'h7FFF_FFFF;
  endfunction

  initial begin
    logic [3:0][15:0] shapes;
    logic [3:0][31:0] shifts;
    int ratios [4];
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every section and fraction extreme at the quadrant edges, ratios at reset
    gap_max = 3;
    for (int k = 0; k < 10; k++) begin
      shapes = {16'(k * 4096 + 1), 16'(k * 4096 + 2048), 16'(k * 4096 + 4095), 16'(k * 4096)};
      for (int i = 0; i < 4; i++) begin
        shifts[i] = PHASE_EDGES[(k + i) % 8];
      end
      send_word('0, shapes, shifts);
    end
    // clamp at ten and above, largest step
    send_word(31'h7FFF_FFFF, {16'd40959, 16'hFFFF, 16'd40961, 16'd40960},
              {32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'h0});
    send_word(31'h7FFF_FFFF, {16'd40960, 16'd45055, 16'd0, 16'hFFFF},
              {32'h0, 32'h7FFF_FFFF, 32'hC000_0000, 32'h8000_0001});
    drain_wait();
    repeat (SETTLE) @(negedge clk);

    // ratio zero, all ones and nominal top; writes past the last lane are dropped
    for (int i = 0; i < qmpo_pkg::LANES; i++) begin
      cfg_write(i, FIRST_RATIOS[i]);
    end
    for (int i = qmpo_pkg::LANES; i < (1 << qmpo_pkg::CFG_IDX_W); i++) begin
      cfg_write(i, (i % 2 == 0) ? 31 : 0);
    end
    settings_used++;
    for (int k = 0; k < 6; k++) begin
      shapes = {16'(k * 8192), 16'(40960 - k * 4096), 16'(k * 4096 + 4095), 16'hFFFF - 16'(k)};
      for (int i = 0; i < 4; i++) begin
        shifts[i] = PHASE_EDGES[(k * 3 + i) % 8];
      end
      send_word((k % 2 == 0) ? 31'h7FFF_FFFF : 31'h0, shapes, shifts);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_wait();
      repeat (SETTLE) @(negedge clk);
      case (ph)
        0: ratios = '{1, 1, 1, 1};
        1: ratios = '{16, 16, 16, 16};
        2: ratios = '{2, 3, 5, 7};
        3: ratios = '{0, 31, 1, 16};
        default: begin
          for (int i = 0; i < 4; i++) begin
            ratios[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
          end
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        cfg_write(i, ratios[i]);
      end
      if (ph % 2 == 1) begin
        cfg_write(qmpo_pkg::LANES + $urandom_range(0, 3), $urandom_range(0, 31));
      end
      settings_used++;
      gap_max = (ph % 3 == 0) ? 0 : 18;
      for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
        if (ph == 2 && n == 40) begin
          long_hold_req = 1'b1;
        end
        if (ph == 4 && n == 60) begin
          drain_wait();
        end
        for (int i = 0; i < 4; i++) begin
          shapes[i] = pick_shape();
          shifts[i] = pick_shift();
        end
        send_word(pick_step(), shapes, shifts);
      end
    end

    drain_wait();
    repeat (SETTLE) @(posedge clk);
    $display("checked %0d words over %0d ratio settings, all ten morph sections and the clamp",
             words_checked, settings_used);
    $display("output held %0d cycles against a busy input, input drained to idle mid-run",
             LONG_HOLD);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ quad_morphing_phase_oscillator_unit.f @@
+incdir+design
design/qmpo_pkg.sv
design/qmpo_lane.sv
design/quad_morphing_phase_oscillator_unit.sv
design/qmpo_checker.sv
verif/quad_morphing_phase_oscillator_unit_checker.sv
verif/quad_morphing_phase_oscillator_unit_tb.sv
